[rtl/deqs_pkg.sv]
// Shared types, sizes and ring index helpers for the double-ended queue with search.
// No dependencies; the top level imports this package, the RAM stands alone.
`default_nettype none
package deqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [4:0]  entry_count;
        logic [3:0]  match_position;
    } t_result;

    // (base + off) mod DEPTH, with base below DEPTH and off at most DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage
`default_nettype wire

[rtl/deqs_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`default_nettype none
module deqs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/double_ended_queue_with_search.sv]
// Top level of the double-ended queue with search: control, ring pointers, scan sequencer.
// Depends on deqs_pkg and deqs_ram.
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+---------------------------------
//  request   | start, busy, i_request    | taken when start && !busy
//  result    | o_strobe, o_result        | one-cycle strobe, never stalled
//
// Pushes, removals and unused codes take one cycle: the result strobes in the
// cycle after the request and the next request may be taken in that same cycle.
// A search walks the held entries through the store's single read port, one per
// cycle, with busy high for the whole walk; a search on an empty queue is
// answered with not-found without a walk, like a push.
// Reset clears pointers, count and the sequencer; store contents are left as is.
// The result side cannot stall, so no result is ever held back.
`default_nettype none
module double_ended_queue_with_search (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire deqs_pkg::t_request i_request,
    output logic                    busy,
    output logic                    o_strobe,
    output deqs_pkg::t_result       o_result
);
    import deqs_pkg::*;

    t_state                r_state,   n_state;
    logic [IDX_W-1:0]      r_front,   n_front;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [DATA_WIDTH-1:0] r_key,     n_key;
    logic [CNT_W-1:0]      r_issue,   n_issue;
    logic [IDX_W-1:0]      r_cmp_pos, n_cmp_pos;
    logic                  r_found,   n_found;
    logic [IDX_W-1:0]      r_match,   n_match;
    logic                  r_strobe,  n_strobe;
    t_result               r_result,  n_result;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [IDX_W-1:0]      raddr;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  hit;
    logic                  last;
    logic                  full;
    logic                  empty;

    deqs_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign word  = DATA_WIDTH'(i_request.value);
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign hit   = (rdata == r_key);
    assign last  = ((CNT_W'(r_cmp_pos) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_issue   <= n_issue;
        r_cmp_pos <= n_cmp_pos;
        r_found   <= n_found;
        r_match   <= n_match;
        r_result  <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_key     = r_key;
        n_issue   = r_issue;
        n_cmp_pos = r_cmp_pos;
        n_found   = r_found;
        n_match   = r_match;
        n_strobe  = 1'b0;
        n_result  = r_result;
        we        = 1'b0;
        waddr     = ring_add(r_front, r_count);
        raddr     = ring_add(r_front, r_issue);
        busy      = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                raddr = r_front;
                if (start) begin
                    n_strobe                = 1'b1;
                    n_result.status         = ST_DONE;
                    n_result.match_position = '0;
                    unique case (i_request.operation)
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                          : r_front - IDX_W'(1);
                                waddr   = n_front;
                                we      = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_front = (r_front == IDX_W'(DEPTH - 1)) ? '0
                                                                         : r_front + IDX_W'(1);
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (empty) begin
                                n_result.status = ST_NOT_FOUND;
                            end else begin
                                // hold the result back until the walk ends
                                n_strobe  = 1'b0;
                                n_key     = word;
                                n_issue   = CNT_W'(1);
                                n_cmp_pos = '0;
                                n_found   = 1'b0;
                                n_match   = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                    n_result.entry_count = 5'(n_count);
                end
            end
            S_SCAN: begin
                // compare the word read last cycle, issue the next read
                if (hit) begin
                    n_found = 1'b1;
                    n_match = r_cmp_pos;
                end
                if (r_issue < r_count) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                n_cmp_pos = r_cmp_pos + IDX_W'(1);
                if (last) begin
                    n_state                 = S_IDLE;
                    n_strobe                = 1'b1;
                    n_result.status         = (hit || r_found) ? ST_DONE : ST_NOT_FOUND;
                    n_result.entry_count    = 5'(r_count);
                    n_result.match_position = hit     ? 4'(r_cmp_pos) :
                                              r_found ? 4'(r_match)   : 4'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire
